// ===== design/wss_pkg.sv =====
// ----------------------------------------------------------------------------
// wss_pkg
// shared types and constants of the waypoint slew sequencer
// ----------------------------------------------------------------------------
package wss_pkg;

  localparam int MaxSteps = 16;
  localparam int AddrW    = $clog2(MaxSteps);
  localparam int QDepth   = 2;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_LOAD,
    OP_DROP
  } op_kind_e;

  typedef struct packed {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic [30:0]        sx;
    logic [30:0]        sy;
    logic [30:0]        sz;
    logic [30:0]        dwell;
  } wp_t;

  localparam int WpW = $bits(wp_t);

  typedef struct packed {
    op_kind_e           kind;
    logic [AddrW-1:0]   slot;
    wp_t                wp;
    logic [15:0]        dt;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } q_slot_t;

endpackage

// ===== design/wss_if.sv =====
// ----------------------------------------------------------------------------
// wss_if
// item, result and configuration channels of the waypoint slew sequencer
// ----------------------------------------------------------------------------
interface wss_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [3:0]         step_index;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;
  logic [30:0]        speed_x;
  logic [30:0]        speed_y;
  logic [30:0]        speed_z;
  logic [30:0]        dwell_time;
  logic [15:0]        delta_time;
  logic signed [31:0] current_x;
  logic signed [63:0] current_yz;

  modport source (
    output valid, command, step_index, target_x, target_y, target_z,
           speed_x, speed_y, speed_z, dwell_time, delta_time, current_x, current_yz,
    input  ready
  );
  modport sink (
    input  valid, command, step_index, target_x, target_y, target_z,
           speed_x, speed_y, speed_z, dwell_time, delta_time, current_x, current_yz,
    output ready
  );
endinterface

interface wss_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value_x;
  logic signed [31:0] value_y;
  logic signed [31:0] value_z;
  logic [3:0]         active_step;
  logic               dwelling;

  modport source (
    output valid, value_x, value_y, value_z, active_step, dwelling,
    input  ready
  );
  modport sink (
    input  valid, value_x, value_y, value_z, active_step, dwelling,
    output ready
  );
endinterface

interface wss_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] step_count;

  modport source (output valid, step_count, input ready);
  modport sink (input valid, step_count, output ready);
endinterface

// ===== design/wss_ram.sv =====
// ----------------------------------------------------------------------------
// wss_ram
// generic ram, one write port, two registered read ports, read-first
// ----------------------------------------------------------------------------
module wss_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AW    = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== design/wss_front.sv =====
// ----------------------------------------------------------------------------
// wss_front
// accepts items and classifies them into tick, load and dropped load
// ----------------------------------------------------------------------------
module wss_front (
  wss_in_if.sink          in_i,
  output wss_pkg::q_slot_t push_o,
  input  logic            push_ready_i
);
  import wss_pkg::*;

  logic slot_ok;

  assign slot_ok     = 32'(in_i.step_index) < MaxSteps;
  assign in_i.ready  = push_ready_i;

  always_comb begin
    push_o.valid    = in_i.valid;
    push_o.op.kind  = !in_i.command ? OP_TICK : (slot_ok ? OP_LOAD : OP_DROP);
    push_o.op.slot  = AddrW'(in_i.step_index);
    push_o.op.wp.tx = in_i.target_x;
    push_o.op.wp.ty = in_i.target_y;
    push_o.op.wp.tz = in_i.target_z;
    push_o.op.wp.sx = in_i.speed_x;
    push_o.op.wp.sy = in_i.speed_y;
    push_o.op.wp.sz = in_i.speed_z;
    push_o.op.wp.dwell = in_i.dwell_time;
    push_o.op.dt    = in_i.delta_time;
    push_o.op.cx    = in_i.current_x;
    push_o.op.cy    = in_i.current_yz[63:32];
    push_o.op.cz    = in_i.current_yz[31:0];
  end

endmodule

// ===== design/wss_queue.sv =====
// ----------------------------------------------------------------------------
// wss_queue
// short fifo between the front and the back
// ----------------------------------------------------------------------------
module wss_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wss_pkg::q_slot_t push_i,
  output logic             push_ready_o,
  output wss_pkg::q_slot_t head_o,
  input  logic             pop_i
);
  import wss_pkg::*;

  op_t        buf_q [QDepth];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign push_ready_o = cnt_q != 2'(QDepth);
  assign do_push      = push_i.valid && push_ready_o;
  assign do_pop       = pop_i && head_o.valid;
  assign head_o.valid = cnt_q != 2'd0;
  assign head_o.op    = buf_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= push_i.op;
    end
  end

endmodule

// ===== design/wss_back.sv =====
// ----------------------------------------------------------------------------
// wss_back
// executes ticks and loads against the waypoint table, output register
// ----------------------------------------------------------------------------
module wss_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wss_pkg::q_slot_t head_i,
  output logic             pop_o,
  wss_cfg_if.sink          cfg_i,
  wss_out_if.source        out_o
);
  import wss_pkg::*;

  function automatic logic [AddrW-1:0] eff_slot(input logic [3:0] p, input logic [4:0] c);
    return ({1'b0, p} < c) ? AddrW'(p) : '0;
  endfunction

  function automatic logic [AddrW-1:0] nxt_slot(input logic [AddrW-1:0] p,
                                                input logic [4:0] c);
    logic [5:0] n;
    n = 6'(p) + 6'd1;
    return (n >= 6'(c)) ? '0 : AddrW'(n);
  endfunction

  function automatic logic signed [31:0] slew(input logic signed [31:0] cur,
                                              input logic signed [31:0] tgt,
                                              input logic [30:0] spd,
                                              input logic [15:0] dt);
    logic [46:0]        prod;
    logic signed [33:0] mv, up, dn, t;
    prod = 47'(spd) * 47'(dt);
    mv   = signed'({3'b000, prod[46:16]});
    t    = 34'(tgt);
    up   = 34'(cur) + mv;
    dn   = 34'(cur) - mv;
    if (cur < tgt) begin
      return (up > t) ? tgt : up[31:0];
    end else if (cur > tgt) begin
      return (dn < t) ? tgt : dn[31:0];
    end
    return cur;
  endfunction

  logic [4:0]         step_count_q, step_count_d;
  logic [4:0]         cnt, cnt_rd;
  logic [3:0]         ptr_q, ptr_d;
  logic signed [32:0] dwell_q, dwell_d;
  logic               ov_q;
  logic               hit_a_q, hit_b_q;
  wp_t                wbuf_q;
  logic [WpW-1:0]     rd_a, rd_b;
  wp_t                wa, wb, sel;
  logic [AddrW-1:0]   pe_cur, pn_cur, raddr_a, raddr_b;
  logic               we, match, is_tick;
  logic signed [31:0] nx, ny, nz;

  assign cfg_i.ready = 1'b1;
  assign step_count_d = cfg_i.valid ? cfg_i.step_count : step_count_q;
  assign cnt     = (step_count_q > 5'(MaxSteps)) ? 5'(MaxSteps) : step_count_q;
  // count seen by the next cycle, so a fresh write steers the table read at once
  assign cnt_rd  = (step_count_d > 5'(MaxSteps)) ? 5'(MaxSteps) : step_count_d;
  assign pop_o   = head_i.valid && (!ov_q || out_o.ready);
  assign is_tick = head_i.op.kind == OP_TICK;
  assign we      = pop_o && head_i.op.kind == OP_LOAD;

  // read data belongs to ptr_q, forwarded when a load hit that slot
  assign wa     = hit_a_q ? wbuf_q : wp_t'(rd_a);
  assign wb     = hit_b_q ? wbuf_q : wp_t'(rd_b);
  assign pe_cur = eff_slot(ptr_q, cnt);
  assign pn_cur = nxt_slot(pe_cur, cnt);
  assign match  = head_i.op.cx == wa.tx && head_i.op.cy == wa.ty && head_i.op.cz == wa.tz;
  assign sel    = match ? wb : wa;

  always_comb begin
    ptr_d   = ptr_q;
    dwell_d = dwell_q;
    nx      = head_i.op.cx;
    ny      = head_i.op.cy;
    nz      = head_i.op.cz;
    if (pop_o && is_tick && cnt != 5'd0) begin
      if (dwell_q > 33'sd0) begin
        dwell_d = dwell_q - $signed({17'b0, head_i.op.dt});
      end else begin
        if (match) begin
          dwell_d = $signed({2'b00, wa.dwell});
        end
        ptr_d = 4'(match ? pn_cur : pe_cur);
        nx = slew(head_i.op.cx, sel.tx, sel.sx, head_i.op.dt);
        ny = slew(head_i.op.cy, sel.ty, sel.sy, head_i.op.dt);
        nz = slew(head_i.op.cz, sel.tz, sel.sz, head_i.op.dt);
      end
    end
  end

  assign raddr_a = eff_slot(ptr_d, cnt_rd);
  assign raddr_b = nxt_slot(raddr_a, cnt_rd);

  wss_ram #(.Width(WpW), .Depth(MaxSteps)) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (head_i.op.slot),
    .wdata_i   (head_i.op.wp),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_count_q <= 5'd0;
      ptr_q        <= 4'd0;
      dwell_q      <= 33'sd0;
      ov_q         <= 1'b0;
      hit_a_q      <= 1'b0;
      hit_b_q      <= 1'b0;
    end else begin
      step_count_q <= step_count_d;
      ptr_q   <= ptr_d;
      dwell_q <= dwell_d;
      hit_a_q <= we && head_i.op.slot == raddr_a;
      hit_b_q <= we && head_i.op.slot == raddr_b;
      if (pop_o) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wbuf_q <= head_i.op.wp;
    if (pop_o) begin
      out_o.value_x     <= nx;
      out_o.value_y     <= ny;
      out_o.value_z     <= nz;
      out_o.active_step <= ptr_d;
      out_o.dwelling    <= dwell_d > 33'sd0;
    end
  end

  assign out_o.valid = ov_q;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_o.ready |-> !pop_o)
    else $error("result overwritten while stalled");
  a_dwell_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dwell_q > -33'sd65536)
    else $error("dwell countdown below one tick");
  a_idle_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && (!is_tick || cnt == 5'd0) |=> $stable(ptr_q) && $stable(dwell_q))
    else $error("state changed on load or pass-through item");
`endif

endmodule

// ===== design/waypoint_slew_sequencer.sv =====
// ----------------------------------------------------------------------------
// waypoint_slew_sequencer
// three-axis waypoint sequencer with per-axis slew limit and dwell
// ----------------------------------------------------------------------------
// One result item comes out for every input item, in order. Items are taken
// one per clock while the queue has room: the front classifies each item and
// puts it in a two-entry queue, the back executes one item per clock into an
// output register unless that register holds a result the sink has not yet
// taken. The waypoint table lives in a small ram that is read at the active
// slot and the slot after it through registered read ports ahead of use; a
// load to one of those slots is forwarded. Slots that were never loaded read
// as garbage. Write step_count only while the block is idle; a tick may
// follow the write right away.
module waypoint_slew_sequencer (
  input  logic      clk_i,
  input  logic      rst_ni,
  wss_in_if.sink    in_i,
  wss_out_if.source out_o,
  wss_cfg_if.sink   cfg_i
);
  import wss_pkg::*;

  // front to queue
  q_slot_t push;
  logic    push_ready;
  // queue to back
  q_slot_t head;
  logic    pop;

  wss_front u_front (
    .in_i         (in_i),
    .push_o       (push),
    .push_ready_i (push_ready)
  );

  // decouples acceptance from execution so each side can stall alone
  wss_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .head_o       (head),
    .pop_i        (pop)
  );

  // table, step pointer, dwell countdown and slew math
  wss_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .cfg_i  (cfg_i),
    .out_o  (out_o)
  );

endmodule
